// File: hdl/fftl_pkg.sv
// shared types, constants and helpers for the feedforward tree layer
package fftl_pkg;

	localparam int MAX_WIDTH   = 64;
	localparam int MAX_DEPTH   = 8;
	localparam int PHI_ENTRIES = 256;
	localparam int DATA_BITS   = 16;
	localparam int ACC_BITS    = 40;
	localparam int PROD_BITS   = 2 * DATA_BITS;
	localparam int POS_BITS    = $clog2(MAX_WIDTH);
	localparam int NODE_BITS   = 8;
	localparam int PHI_BITS    = $clog2(PHI_ENTRIES);
	localparam int STORE_DEPTH = (1 << (NODE_BITS + POS_BITS));
	localparam logic [NODE_BITS-1:0] NODE_NONE = 8'hFF;

	localparam logic signed [ACC_BITS-1:0] DATA_MAX_W = 40'sd32767;
	localparam logic signed [ACC_BITS-1:0] DATA_MIN_W = -40'sd32768;

	typedef enum logic [1:0] {
		ACT_LOAD_IN  = 2'd0,
		ACT_LOAD_OUT = 2'd1,
		ACT_LOAD_PHI = 2'd2,
		ACT_ELEMENT  = 2'd3
	} action_t;

	typedef enum logic {
		REG_TREE_DEPTH   = 1'b0,
		REG_VECTOR_WIDTH = 1'b1
	} reg_index_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DOT,
		ST_SCORE,
		ST_PHI_RD,
		ST_GELU_MUL,
		ST_GELU,
		ST_ACC,
		ST_NEXT,
		ST_OUT_RD,
		ST_OUT_LD,
		ST_OUT_HOLD
	} state_t;

	typedef struct packed {
		logic                        clip;
		logic signed [DATA_BITS-1:0] value;
	} sat_t;

	// saturate a wide signed value to the data width
	function automatic sat_t sat_data(input logic signed [ACC_BITS-1:0] v);
		sat_t r;
		if (v > DATA_MAX_W) begin
			r.clip  = 1'b1;
			r.value = DATA_MAX_W[DATA_BITS-1:0];
		end else if (v < DATA_MIN_W) begin
			r.clip  = 1'b1;
			r.value = DATA_MIN_W[DATA_BITS-1:0];
		end else begin
			r.clip  = 1'b0;
			r.value = v[DATA_BITS-1:0];
		end
		return r;
	endfunction

endpackage

// File: hdl/fftl_mac.sv
// shared signed multiplier with registered product
module fftl_mac
	import fftl_pkg::*;
(
	input  logic                         clk,
	input  logic signed [DATA_BITS-1:0]  a,
	input  logic signed [DATA_BITS-1:0]  b,
	output logic signed [PROD_BITS-1:0]  p_q
);

	always_ff @(posedge clk) begin
		p_q <= a * b;
	end

endmodule

// File: hdl/fast_feedforward_tree_layer_top.sv
// top level of the feedforward tree layer: stores, sequencer and output stage
//
//  channel | signals                                           | handshake
//  --------+---------------------------------------------------+-----------
//  in      | action node position table_index value            | in_valid/in_ready
//  out     | out_index out_value saturated last                | out_valid/out_ready
//  cfg     | cfg_index cfg_data                                | cfg_we, no wait
//
// load items are written to their store when accepted; an element item that closes the vector starts a walk
// walk: per level a dot product, score, table read, GELU product and accumulate, all products through one multiplier
// then each output item is read, loaded and held until out_ready takes it
// reset clears control state and configuration registers; stores, table and datapath registers hold no reset
// input is not ready from the start of a walk until the last output item is taken
module fast_feedforward_tree_layer_top
	import fftl_pkg::*;
(
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic                         cfg_index,
	input  logic [6:0]                   cfg_data,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [1:0]                   action,
	input  logic [NODE_BITS-1:0]         node,
	input  logic [POS_BITS-1:0]          position,
	input  logic [PHI_BITS-1:0]          table_index,
	input  logic signed [DATA_BITS-1:0]  value,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [POS_BITS-1:0]          out_index,
	output logic signed [DATA_BITS-1:0]  out_value,
	output logic                         saturated,
	output logic                         last
);

	// configuration registers
	logic [3:0] depth_q;
	logic [6:0] width_q;
	logic [3:0] depth_eff;
	logic [6:0] width_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= 4'd8;
			width_q <= 7'd64;
		end else if (cfg_we) begin
			case (reg_index_t'(cfg_index))
				REG_TREE_DEPTH:   depth_q <= cfg_data[3:0];
				REG_VECTOR_WIDTH: width_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// clamp to the supported ranges
	assign depth_eff = (depth_q == 4'd0) ? 4'd1 :
		(depth_q > 4'(MAX_DEPTH)) ? 4'(MAX_DEPTH) : depth_q;
	assign width_eff = (width_q == 7'd0) ? 7'd1 :
		(width_q > 7'(MAX_WIDTH)) ? 7'(MAX_WIDTH) : width_q;

	// sequencer state
	state_t state_q, state_d;
	logic [6:0]               cnt_q;
	logic [3:0]               level_q;
	logic [NODE_BITS-1:0]     node_q;
	logic                     v1_q, v2_q;
	logic [POS_BITS-1:0]      j_s1, j_s2;
	logic signed [ACC_BITS-1:0]  sum_q;
	logic signed [DATA_BITS-1:0] s_q, g_q;
	logic signed [ACC_BITS-1:0]  acc_s2;
	logic out_valid_q;

	// stores
	logic signed [DATA_BITS-1:0] in_w_mem  [STORE_DEPTH];
	logic signed [DATA_BITS-1:0] out_w_mem [STORE_DEPTH];
	logic signed [DATA_BITS-1:0] phi_mem   [PHI_ENTRIES];
	logic signed [DATA_BITS-1:0] tok_mem   [MAX_WIDTH];
	logic signed [ACC_BITS-1:0]  acc_mem   [MAX_WIDTH];

	logic signed [DATA_BITS-1:0] in_w_rd, out_w_rd, phi_rd, tok_rd;
	logic signed [ACC_BITS-1:0]  acc_rd;

	// control decode
	logic accept, start_walk, issue, dot_rd, acc_phase_rd, out_rd, phi_rd_en;
	logic drained, out_take;
	logic signed [DATA_BITS-1:0] mul_a, mul_b;
	logic signed [PROD_BITS-1:0] prod_q;
	logic signed [ACC_BITS-1:0]  prod_w;
	logic [PHI_BITS-1:0]         phi_ix;
	logic [POS_BITS-1:0]         idx;
	sat_t score_sat, gelu_sat, out_sat;

	assign accept     = in_valid && in_ready;
	assign start_walk = accept && (action_t'(action) == ACT_ELEMENT)
		&& ({1'b0, position} == width_eff - 7'd1);
	assign issue      = (cnt_q < width_eff);
	assign drained    = !issue && !v1_q && !v2_q;
	assign out_take   = out_valid_q && out_ready;
	assign idx        = cnt_q[POS_BITS-1:0];
	// table index is (s >> 8) + 128, i.e. the top byte with its sign bit flipped
	assign phi_ix     = {~s_q[DATA_BITS-1], s_q[DATA_BITS-2:DATA_BITS-8]};
	assign prod_w     = ACC_BITS'(prod_q);

	assign score_sat = sat_data(sum_q >>> 12);
	assign gelu_sat  = sat_data(prod_w >>> 15);
	assign out_sat   = sat_data(acc_rd >>> 12);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:     if (start_walk) state_d = ST_DOT;
			ST_DOT:      if (drained) state_d = ST_SCORE;
			ST_SCORE:    state_d = ST_PHI_RD;
			ST_PHI_RD:   state_d = ST_GELU_MUL;
			ST_GELU_MUL: state_d = ST_GELU;
			ST_GELU:     state_d = ST_ACC;
			ST_ACC:      if (drained) state_d = ST_NEXT;
			ST_NEXT:     state_d = (level_q + 4'd1 == depth_eff) ? ST_OUT_RD : ST_DOT;
			ST_OUT_RD:   state_d = ST_OUT_LD;
			ST_OUT_LD:   state_d = ST_OUT_HOLD;
			ST_OUT_HOLD: if (out_take) state_d = last ? ST_IDLE : ST_OUT_RD;
			default:     state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		in_ready     = 1'b0;
		dot_rd       = 1'b0;
		acc_phase_rd = 1'b0;
		out_rd       = 1'b0;
		phi_rd_en    = 1'b0;
		mul_a        = tok_rd;
		mul_b        = in_w_rd;
		case (state_q)
			ST_IDLE:     in_ready = 1'b1;
			ST_DOT:      dot_rd = issue;
			ST_PHI_RD:   phi_rd_en = 1'b1;
			ST_GELU_MUL: begin
				mul_a = s_q;
				mul_b = phi_rd;
			end
			ST_ACC: begin
				acc_phase_rd = issue;
				mul_a        = g_q;
				mul_b        = out_w_rd;
			end
			ST_OUT_RD:   out_rd = 1'b1;
			default: ;
		endcase
	end

	fftl_mac u_mac (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (prod_q)
	);

	// store writes and registered reads
	always_ff @(posedge clk) begin
		if (accept) begin
			case (action_t'(action))
				ACT_LOAD_IN:  if (node != NODE_NONE) in_w_mem[{node, position}] <= value;
				ACT_LOAD_OUT: if (node != NODE_NONE) out_w_mem[{node, position}] <= value;
				ACT_LOAD_PHI: phi_mem[table_index] <= value;
				ACT_ELEMENT:  tok_mem[position] <= value;
				default: ;
			endcase
		end
		if (dot_rd) begin
			tok_rd  <= tok_mem[idx];
			in_w_rd <= in_w_mem[{node_q, idx}];
		end
		if (acc_phase_rd) out_w_rd <= out_w_mem[{node_q, idx}];
		if (acc_phase_rd || out_rd) acc_rd <= acc_mem[idx];
		if (phi_rd_en) phi_rd <= phi_mem[phi_ix];
		// first level overwrites, which clears the accumulators per walk
		if (state_q == ST_ACC && v2_q)
			acc_mem[j_s2] <= (level_q == 4'd0) ? prod_w : acc_s2 + prod_w;
	end

	// datapath registers
	always_ff @(posedge clk) begin
		j_s1   <= idx;
		j_s2   <= j_s1;
		acc_s2 <= acc_rd;
		if (state_q == ST_IDLE || state_q == ST_NEXT)
			sum_q <= '0;
		else if (state_q == ST_DOT && v2_q)
			sum_q <= sum_q + prod_w;
		if (state_q == ST_SCORE) s_q <= score_sat.value;
		if (state_q == ST_GELU) g_q <= gelu_sat.value;
		if (state_q == ST_OUT_LD) begin
			out_index <= idx;
			out_value <= out_sat.value;
			saturated <= out_sat.clip;
			last      <= (cnt_q == width_eff - 7'd1);
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			level_q     <= '0;
			node_q      <= '0;
			v1_q        <= 1'b0;
			v2_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			v1_q    <= dot_rd || acc_phase_rd;
			v2_q    <= v1_q;
			case (state_q)
				ST_IDLE: begin
					cnt_q   <= '0;
					level_q <= '0;
					node_q  <= '0;
				end
				ST_DOT, ST_ACC: if (issue) cnt_q <= cnt_q + 7'd1;
				ST_GELU: cnt_q <= '0;
				ST_NEXT: begin
					cnt_q <= '0;
					if (level_q + 4'd1 == depth_eff) begin
						node_q <= '0;
					end else begin
						level_q <= level_q + 4'd1;
						node_q  <= {node_q[NODE_BITS-2:0], 1'b0}
							+ ((s_q > 0) ? 8'd2 : 8'd1);
					end
				end
				ST_OUT_LD: out_valid_q <= 1'b1;
				ST_OUT_HOLD: if (out_take) begin
					out_valid_q <= 1'b0;
					cnt_q       <= cnt_q + 7'd1;
				end
				default: ;
			endcase
		end
	end

	assign out_valid = out_valid_q;

	// no new item while a result is pending
	a_ready_excl: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !out_valid)
		else $error("input ready while an output item is pending");

	// the walk never reaches the unused node
	a_node_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DOT || state_q == ST_ACC) |-> node_q != NODE_NONE)
		else $error("walk reached a node beyond the tree");

	// level stays below the clamped depth
	a_level: assert property (@(posedge clk) disable iff (!arst_n)
		level_q < depth_eff || state_q == ST_IDLE)
		else $error("level counter overran the tree depth");

	// a stalled output item holds its data
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_index))
		else $error("output item changed while stalled");

endmodule
